[src/mswl_pkg.sv]
package mswl_pkg;

  // Field widths fixed by the interface
  localparam int SAMPLE_W    = 16;
  localparam int START_W     = 10;
  localparam int BEST_SUM_W  = 20;
  localparam int CFG_W       = 5;

  // Queue entry carries the window length at the widest legal WINDOW_MAX (64)
  localparam int LEN_ENT_W   = 7;
  localparam int QUEUE_DEPTH = 2;

  // Parameter defaults
  localparam int WINDOW_MAX_DEFAULT = 16;
  localparam int MAX_LEN_DEFAULT    = 1024;

  localparam logic [CFG_W-1:0] WINDOW_LEN_RESET = 5'd10;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_word_t;

  typedef struct packed {
    logic [START_W-1:0]           best_start;
    logic signed [BEST_SUM_W-1:0] best_sum;
    logic                         found;
  } out_word_t;

  // Classified word handed from front to back
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       cand;   // full window in range ends here
    logic [START_W-1:0]         start;  // window start, low bits
    logic [LEN_ENT_W-1:0]       len;    // effective window length
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t ent;
  } stage_t;

endpackage

[src/mswl_front.sv]
module mswl_front #(
  parameter int WINDOW_MAX = mswl_pkg::WINDOW_MAX_DEFAULT,
  parameter int MAX_LEN    = mswl_pkg::MAX_LEN_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  mswl_pkg::in_word_t           in_word_i,
  input  logic                         cfg_we_i,
  input  logic [mswl_pkg::CFG_W-1:0]   cfg_wdata_i,
  output logic                         q_push_o,
  output mswl_pkg::entry_t             q_entry_o,
  input  logic                         q_ready_i
);
  import mswl_pkg::*;

  localparam int LenW = $clog2(WINDOW_MAX + 1);
  localparam int CntW = $clog2(MAX_LEN + 2);
  localparam int CmpW = CFG_W + LenW;
  localparam int WW   = CntW + LenW;

  logic [CFG_W-1:0]       window_len_q;
  logic [CntW-1:0]        count_q, count_d, count_inc;
  logic [LenW-1:0]        len_eff;
  logic                   accept;
  logic [WW-1:0]          start_full;
  logic [WW+START_W-1:0]  start_ext;

  assign accept     = in_valid_i & q_ready_i;
  assign in_ready_o = q_ready_i;
  assign q_push_o   = accept;

  // zero acts as 1, anything above WINDOW_MAX clamps
  always_comb begin
    if (window_len_q == '0) begin
      len_eff = LenW'(1);
    end else if (CmpW'(window_len_q) > CmpW'(WINDOW_MAX)) begin
      len_eff = LenW'(WINDOW_MAX);
    end else begin
      len_eff = LenW'(window_len_q);
    end
  end

  // saturates at MAX_LEN + 1
  assign count_inc  = (count_q <= CntW'(MAX_LEN)) ? count_q + CntW'(1) : count_q;
  assign start_full = WW'(count_inc) - WW'(len_eff);
  assign start_ext  = (WW + START_W)'(start_full);

  always_comb begin
    q_entry_o.sample = in_word_i.sample;
    q_entry_o.last   = in_word_i.last;
    q_entry_o.cand   = (WW'(count_inc) >= WW'(len_eff)) && (count_inc <= CntW'(MAX_LEN));
    q_entry_o.start  = start_ext[START_W-1:0];
    q_entry_o.len    = LEN_ENT_W'(len_eff);
  end

  always_comb begin
    count_d = count_q;
    if (accept) begin
      count_d = in_word_i.last ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= WINDOW_LEN_RESET;
      count_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        window_len_q <= cfg_wdata_i;
      end
      count_q <= count_d;
    end
  end

endmodule

[src/mswl_queue.sv]
module mswl_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mswl_pkg::entry_t entry_i,
  output logic             ready_o,
  output logic             valid_o,
  output mswl_pkg::entry_t entry_o,
  input  logic             pop_i
);
  import mswl_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  entry_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign ready_o = cnt_q != CntW'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

[src/mswl_back.sv]
module mswl_back #(
  parameter int WINDOW_MAX = mswl_pkg::WINDOW_MAX_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  mswl_pkg::entry_t    q_entry_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mswl_pkg::out_word_t out_word_o
);
  import mswl_pkg::*;

  localparam int Depth = $clog2(WINDOW_MAX);
  localparam int P     = 1 << Depth;
  localparam int Nodes = 2 * P - 1;
  localparam int SumW  = SAMPLE_W + Depth;

  logic signed [SAMPLE_W-1:0]   taps_q [WINDOW_MAX];
  logic signed [SumW-1:0]       leaf_d [P];
  logic signed [SumW-1:0]       node_q [Nodes];
  stage_t                       meta_q [Depth+1];
  stage_t                       tail;
  logic signed [SumW-1:0]       tail_sum;

  logic                         adv, take;
  logic                         min_valid_q, min_valid_d;
  logic signed [SumW-1:0]       min_sum_q, min_sum_d;
  logic [START_W-1:0]           min_start_q, min_start_d;
  logic                         load_out;
  logic                         out_valid_q;
  out_word_t                    out_word_q;
  logic signed [SumW+BEST_SUM_W-1:0] sum_ext;

  assign tail     = meta_q[Depth];
  assign tail_sum = node_q[Nodes-1];

  // whole pipe holds only when a result is ready but the output slot is taken
  assign adv      = !(tail.valid && tail.ent.last && out_valid_q && !out_ready_i);
  assign take     = adv & q_valid_i;
  assign q_pop_o  = take;
  assign load_out = adv & tail.valid & tail.ent.last;

  // leaves: newest sample at index 0, masked to the word's window length
  always_comb begin
    for (int k = 0; k < P; k++) begin
      leaf_d[k] = '0;
      if (k < WINDOW_MAX && LEN_ENT_W'(k) < q_entry_i.len) begin
        if (k == 0) begin
          leaf_d[k] = SumW'(q_entry_i.sample);
        end else begin
          leaf_d[k] = SumW'(taps_q[k-1]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      taps_q[0] <= q_entry_i.sample;
      for (int k = 1; k < WINDOW_MAX; k++) begin
        taps_q[k] <= taps_q[k-1];
      end
    end
    if (adv) begin
      for (int k = 0; k < P; k++) begin
        node_q[k] <= leaf_d[k];
      end
      // level l starts at 2P - (2P >> l)
      for (int l = 1; l <= Depth; l++) begin
        for (int j = 0; j < (P >> l); j++) begin
          node_q[2*P - ((2*P) >> l) + j] <=
            node_q[2*P - ((2*P) >> (l-1)) + 2*j] +
            node_q[2*P - ((2*P) >> (l-1)) + 2*j + 1];
        end
      end
    end
  end

  // running minimum, updated before a last word reports it
  always_comb begin
    min_valid_d = min_valid_q;
    min_sum_d   = min_sum_q;
    min_start_d = min_start_q;
    if (tail.valid && tail.ent.cand && (!min_valid_q || tail_sum < min_sum_q)) begin
      min_valid_d = 1'b1;
      min_sum_d   = tail_sum;
      min_start_d = tail.ent.start;
    end
  end

  assign sum_ext = (SumW + BEST_SUM_W)'(min_sum_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= Depth; s++) begin
        meta_q[s] <= '0;
      end
      min_valid_q <= 1'b0;
      min_sum_q   <= '0;
      min_start_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        meta_q[0].valid <= q_valid_i;
        meta_q[0].ent   <= q_entry_i;
        for (int s = 1; s <= Depth; s++) begin
          meta_q[s] <= meta_q[s-1];
        end
        if (load_out) begin
          min_valid_q <= 1'b0;
          min_sum_q   <= '0;
          min_start_q <= '0;
        end else begin
          min_valid_q <= min_valid_d;
          min_sum_q   <= min_sum_d;
          min_start_q <= min_start_d;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_word_q.found      <= min_valid_d;
      out_word_q.best_start <= min_valid_d ? min_start_d : '0;
      out_word_q.best_sum   <= min_valid_d ? sum_ext[BEST_SUM_W-1:0] : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

[src/min_sum_window_locator_core.sv]
// Minimum-sum window locator.
// Input channel (in_valid_i/in_ready_o/in_word_i): one signed sample per word;
// the word with last set closes a sequence. Output channel (out_valid_o/
// out_ready_i/out_word_o): one word per sequence, carrying the 0-based start
// of the window of window_len samples with the smallest sum (earliest wins a
// tie), that sum, and found = 0 when the sequence was shorter than the window.
// Windows ending past MAX_LEN samples do not take part.
// Config: cfg_we_i writes window_len (0 acts as 1, clamps to WINDOW_MAX).
// Throughput: one word per cycle while the back pipe is not held. From accepting
// the last word, the result passes the queue slot, the leaf register, one
// register per adder-tree level and the output register to out_valid_o.
// Reset: window_len returns to 10, counters, queue and pipe empty.
// A stalled receiver holds the whole back pipe only while a finished result
// is blocked; the two-word queue then fills and in_ready_o drops.
module min_sum_window_locator_core #(
  parameter int WINDOW_MAX = mswl_pkg::WINDOW_MAX_DEFAULT,
  parameter int MAX_LEN    = mswl_pkg::MAX_LEN_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  mswl_pkg::in_word_t         in_word_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output mswl_pkg::out_word_t        out_word_o,
  input  logic                       cfg_we_i,
  input  logic [mswl_pkg::CFG_W-1:0] cfg_wdata_i
);
  import mswl_pkg::*;

  // front -> queue
  logic   push, q_ready;
  entry_t push_entry;
  // queue -> back
  logic   q_valid, pop;
  entry_t head_entry;

  // front: window length register, sample counter, window classification
  mswl_front #(
    .WINDOW_MAX (WINDOW_MAX),
    .MAX_LEN    (MAX_LEN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_push_o    (push),
    .q_entry_o   (push_entry),
    .q_ready_i   (q_ready)
  );

  // decoupling queue
  mswl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .entry_o (head_entry),
    .pop_i   (pop)
  );

  // back: sample taps, pipelined adder tree, running minimum, output register
  mswl_back #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (head_entry),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

[test/tb.sv]
module tb;
  import mswl_pkg::*;

  // Settle time for the result pipe, with margin, before a register write and
  // before the final verdict.
  localparam int PIPE_SETTLE = 16;
  localparam int CLK_HALF    = 6;
  localparam int RUN_LIMIT   = 2 * CLK_HALF * 400000;

  // Scoreboard: tracks the block's stream state and holds the result words
  // still owed by the block, oldest first.
  class min_window_board;
    logic [CFG_W-1:0]           win_len = WINDOW_LEN_RESET;
    logic signed [SAMPLE_W-1:0] ring [WINDOW_MAX_DEFAULT];
    int unsigned                ring_ptr = 0;
    int unsigned                seen = 0;
    int unsigned                best_start = 0;
    logic signed [20:0]         best_sum = '0;
    bit                         best_valid = 1'b0;
    out_word_t                  pending [$];
    int unsigned                errors = 0;

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Zero acts as one, anything above the ring size clamps to it.
    function int unsigned eff_len();
      if (win_len == '0) return 1;
      if (win_len > WINDOW_MAX_DEFAULT) return WINDOW_MAX_DEFAULT;
      return win_len;
    endfunction

    function void note_sample(in_word_t w);
      int unsigned        len;
      int unsigned        pos;
      int unsigned        k;
      logic signed [20:0] acc;
      out_word_t          r;
      len = eff_len();
      ring[ring_ptr] = w.sample;
      ring_ptr = (ring_ptr + 1) % WINDOW_MAX_DEFAULT;
      if (seen <= MAX_LEN_DEFAULT) seen++;
      acc = '0;
      pos = ring_ptr;
      for (k = 0; k < len; k++) begin
        pos = (pos + WINDOW_MAX_DEFAULT - 1) % WINDOW_MAX_DEFAULT;
        acc += ring[pos];
      end
      // Strict less-than keeps the earliest start on a tie.
      if (seen >= len && seen <= MAX_LEN_DEFAULT) begin
        if (!best_valid || acc < best_sum) begin
          best_sum   = acc;
          best_start = seen - len;
          best_valid = 1'b1;
        end
      end
      if (w.last) begin
        r = '0;
        if (best_valid) begin
          r.best_start = START_W'(best_start);
          r.best_sum   = best_sum[BEST_SUM_W-1:0];
          r.found      = 1'b1;
        end
        pending.push_back(r);
        seen       = 0;
        best_sum   = '0;
        best_start = 0;
        best_valid = 1'b0;
      end
    endfunction

    task check_result(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected word start=%0d sum=%0d found=%0b",
                                  got.best_start, got.best_sum, got.found));
        return;
      end
      want = pending.pop_front();
      if (got.best_start !== want.best_start)
        report_mismatch($sformatf("best_start got %0d want %0d",
                                  got.best_start, want.best_start));
      if (got.best_sum !== want.best_sum)
        report_mismatch($sformatf("best_sum got %0d want %0d",
                                  got.best_sum, want.best_sum));
      if (got.found !== want.found)
        report_mismatch($sformatf("found got %0b want %0b", got.found, want.found));
    endtask
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  in_word_t             in_word_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_word_t            out_word_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  // Idle odds in percent for each side; changed between test phases.
  int unsigned send_idle_pct = 38;
  int unsigned recv_idle_pct = 88;

  min_window_board board = new;

  min_sum_window_locator_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Output side: sample the handshake as it stood before the edge, then pick
  // the ready for the next cycle at random.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) board.check_result(out_word_o);
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Input side. Valid is left high after an accepted word; the next call
  // either keeps it high with a new payload or drops it for an idle gap, so
  // valid never gets two updates in one step.
  task automatic send_word(logic signed [SAMPLE_W-1:0] value, bit close);
    in_word_t w;
    w.sample = value;
    w.last   = close;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_sample(w);
  endtask

  task automatic send_run(logic signed [SAMPLE_W-1:0] value, int unsigned count,
                          bit close);
    int unsigned i;
    for (i = 0; i < count; i++) send_word(value, close && (i == count - 1));
  endtask

  // Stop sending and wait until every owed result word has been taken.
  // The loop waits for a clock edge before its first check, so a following raise of valid is a new step.
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending.size() != 0);
  endtask

  // Register writes happen only with the block drained; samples that owe no
  // result may still be in the pipe, so let it settle first.
  task automatic write_window_len(logic [CFG_W-1:0] v);
    hold_until_drained();
    repeat (PIPE_SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    board.win_len = v;
  endtask

  // Lengths lean on the clamp edges: 0, 1, 16 and the out-of-range values.
  function automatic logic [CFG_W-1:0] pick_len();
    case ($urandom_range(7))
      0:       return '0;
      1:       return CFG_W'(1);
      2:       return CFG_W'(WINDOW_MAX_DEFAULT);
      3:       return CFG_W'($urandom_range(31, WINDOW_MAX_DEFAULT + 1));
      default: return CFG_W'($urandom_range(WINDOW_MAX_DEFAULT, 1));
    endcase
  endfunction

  // Full-scale values, small values that make ties likely, and full random.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2, 3, 4: return SAMPLE_W'($urandom_range(16) - 8);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Whole sequences with random content; most are long enough to hold
  // several windows, some are shorter than the window.
  task automatic send_random_sequences(int unsigned n_items);
    int unsigned sent;
    int unsigned seq_len;
    int unsigned len_eff;
    int unsigned i;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) write_window_len(pick_len());
      len_eff = board.eff_len();
      if ($urandom_range(3) == 0) seq_len = $urandom_range(len_eff, 1);
      else seq_len = $urandom_range(3 * len_eff + 4, len_eff);
      for (i = 0; i < seq_len; i++) begin
        // now and then the length changes inside a sequence
        if (i != 0 && $urandom_range(49) == 0) write_window_len(pick_len());
        send_word(pick_sample(), i == seq_len - 1);
      end
      if ($urandom_range(19) == 0) hold_until_drained();
      sent += seq_len;
    end
  endtask

  // Sequence longer than MAX_LEN: the deepest in-range window starts at
  // MAX_LEN - 16; later windows are smaller still but must be ignored, and
  // the sample counter saturates along the way.
  task automatic send_long_sequence();
    int unsigned i;
    write_window_len(CFG_W'(WINDOW_MAX_DEFAULT));
    for (i = 0; i < MAX_LEN_DEFAULT + 16; i++) begin
      if (i < MAX_LEN_DEFAULT - WINDOW_MAX_DEFAULT)
        send_word(SAMPLE_W'($urandom_range(32767)), 1'b0);
      else if (i < MAX_LEN_DEFAULT)
        send_word(-16'sd32767, 1'b0);
      else
        send_word(16'sh8000, i == MAX_LEN_DEFAULT + 15);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Reset length 10: a stream shorter than the window.
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sd0, 1'b1);
    // Length 0 acts as 1; equal minima keep the earliest start.
    write_window_len('0);
    send_word(16'sd5, 1'b0);
    send_word(-16'sd3, 1'b0);
    send_word(-16'sd3, 1'b0);
    send_word(16'sd7, 1'b1);
    send_word(-16'sd1, 1'b1);
    // Length changed inside a sequence.
    write_window_len(CFG_W'(2));
    send_word(16'sd4, 1'b0);
    send_word(16'sd1, 1'b0);
    send_word(16'sd1, 1'b0);
    write_window_len(CFG_W'(3));
    send_word(-16'sd2, 1'b0);
    send_word(16'sd0, 1'b1);
    // All ones in cfg clamps to 16: most negative and most positive sums.
    write_window_len('1);
    send_run(16'sh8000, WINDOW_MAX_DEFAULT, 1'b1);
    send_run(16'sh7fff, WINDOW_MAX_DEFAULT, 1'b1);

    // Random part, one chunk per idle setting.
    send_random_sequences(234);
    hold_until_drained();
    send_idle_pct = 88;
    recv_idle_pct = 38;
    send_random_sequences(234);
    hold_until_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_long_sequence();
    send_random_sequences(234);

    hold_until_drained();
    repeat (PIPE_SETTLE) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("min_sum_window_locator_core test passed");
    end else begin
      $display("min_sum_window_locator_core test failed");
    end
    $finish;
  end

  // Watchdog: a hang or a missing result word ends here.
  initial begin
    #RUN_LIMIT;
    $display("min_sum_window_locator_core test failed");
    $finish;
  end

endmodule
